FILE: rtl/core/lct_pkg.sv
// Package: sizes, sequencer states, store request and result types for the LRU cache tag lookup.
`timescale 1ns / 1ps

package lct_pkg;

  localparam int ENTRIES = 128;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int RANK_W  = IDX_W;
  localparam int KEY_W   = 31;
  localparam int SLOT_W  = 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_DONE
  } state_t;

  // One cycle of traffic to the key and rank stores
  typedef struct packed {
    logic [IDX_W-1:0]  rd_addr;
    logic              key_we;
    logic              rank_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [KEY_W-1:0]  key_wdata;
    logic [RANK_W-1:0] rank_wdata;
  } mem_req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } res_t;

endpackage

FILE: rtl/core/lct_if.sv
// Interfaces: request and response channels of the LRU cache tag lookup.
`timescale 1ns / 1ps

interface lct_req_if;
  logic                     valid;
  logic                     ready;
  logic [lct_pkg::KEY_W-1:0] request_key;

  modport source (output valid, output request_key, input ready);
  modport sink (input valid, input request_key, output ready);
endinterface

interface lct_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [lct_pkg::SLOT_W-1:0] slot;
  logic                      evicted;
  logic [lct_pkg::KEY_W-1:0]  evicted_key;

  modport source (output valid, output hit, output slot, output evicted, output evicted_key,
                  input ready);
  modport sink (input valid, input hit, input slot, input evicted, input evicted_key,
                output ready);
endinterface

FILE: rtl/core/lru_cache_tag_lookup.sv
// The store read port is walked twice per word, to scan keys and find the oldest slot, then to
// rewrite ranks; the scan pass is skipped while the cache is empty. A new word is accepted only
// once the previous result has left the sequencer for the output register.
// Reset (rst, synchronous): empties the cache (fill count zero); key and rank stores
// are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module lru_cache_tag_lookup (
  input logic       clk,
  input logic       rst,
  lct_req_if.sink   req,
  lct_rsp_if.source rsp
);

  lct_pkg::mem_req_t          mreq;
  logic [lct_pkg::KEY_W-1:0]  key_rdata;
  logic [lct_pkg::RANK_W-1:0] rank_rdata;
  logic                       idle;
  logic                       res_valid;
  logic                       res_ready;
  lct_pkg::res_t              res;
  logic                       out_valid;

  assign req.ready = idle;

  lct_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (req.valid && idle),
    .start_key  (req.request_key),
    .idle       (idle),
    .mreq       (mreq),
    .key_rdata  (key_rdata),
    .rank_rdata (rank_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  lct_store u_store (
    .clk        (clk),
    .mreq       (mreq),
    .key_rdata  (key_rdata),
    .rank_rdata (rank_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp.hit         <= res.hit;
      rsp.slot        <= res.slot;
      rsp.evicted     <= res.evicted;
      rsp.evicted_key <= res.evicted_key;
    end
  end

  assign rsp.valid = out_valid;

endmodule

FILE: rtl/core/lct_store.sv
// Key and recency rank stores: one write and one registered read per cycle.
`timescale 1ns / 1ps

module lct_store (
  input  logic                       clk,
  input  lct_pkg::mem_req_t          mreq,
  output logic [lct_pkg::KEY_W-1:0]  key_rdata,
  output logic [lct_pkg::RANK_W-1:0] rank_rdata
);

  logic [lct_pkg::KEY_W-1:0]  key_mem  [lct_pkg::ENTRIES];
  logic [lct_pkg::RANK_W-1:0] rank_mem [lct_pkg::ENTRIES];

  // Write port
  always_ff @(posedge clk) begin
    if (mreq.key_we) begin
      key_mem[mreq.wr_addr] <= mreq.key_wdata;
    end
    if (mreq.rank_we) begin
      rank_mem[mreq.wr_addr] <= mreq.rank_wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    key_rdata  <= key_mem[mreq.rd_addr];
    rank_rdata <= rank_mem[mreq.rd_addr];
  end

endmodule

FILE: rtl/core/lct_ctrl.sv
// Sequencer: key scan, replacement choice and rank update pass over the stores.
`timescale 1ns / 1ps

module lct_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lct_pkg::KEY_W-1:0]  start_key,
  output logic                       idle,
  output lct_pkg::mem_req_t          mreq,
  input  logic [lct_pkg::KEY_W-1:0]  key_rdata,
  input  logic [lct_pkg::RANK_W-1:0] rank_rdata,
  output logic                       res_valid,
  input  logic                       res_ready,
  output lct_pkg::res_t              res
);

  lct_pkg::state_t state, state_next;

  logic [lct_pkg::CNT_W-1:0]  filled;
  logic [lct_pkg::CNT_W-1:0]  cnt;
  logic                       rd_pend;
  logic [lct_pkg::IDX_W-1:0]  rd_idx;
  logic                       issue;

  logic [lct_pkg::KEY_W-1:0]  req_key;
  logic                       found;
  logic [lct_pkg::IDX_W-1:0]  match_slot;
  logic [lct_pkg::RANK_W-1:0] match_rank;
  logic [lct_pkg::IDX_W-1:0]  best_slot;
  logic [lct_pkg::RANK_W-1:0] best_rank;
  logic [lct_pkg::KEY_W-1:0]  best_key;

  logic [lct_pkg::IDX_W-1:0]  upd_slot;
  logic [lct_pkg::RANK_W-1:0] limit;
  logic                       age_all;

  logic                       full;
  logic [lct_pkg::IDX_W-1:0]  target;

  assign full = (filled == lct_pkg::CNT_W'(lct_pkg::ENTRIES));
  assign idle = (state == lct_pkg::S_IDLE);
  assign res_valid = (state == lct_pkg::S_DONE);

  // Slot that receives the key: matching slot, next free slot, or the victim
  always_comb begin
    if (found) begin
      target = match_slot;
    end else if (!full) begin
      target = filled[lct_pkg::IDX_W-1:0];
    end else begin
      target = best_slot;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lct_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and store traffic
  always_comb begin
    state_next      = state;
    issue           = 1'b0;
    mreq            = '0;
    mreq.rd_addr    = cnt[lct_pkg::IDX_W-1:0];
    mreq.key_wdata  = req_key;
    case (state)
      lct_pkg::S_IDLE: begin
        if (start) begin
          state_next = (filled == '0) ? lct_pkg::S_DECIDE : lct_pkg::S_SCAN;
        end
      end
      lct_pkg::S_SCAN: begin
        issue = (cnt < filled);
        if (!issue && !rd_pend) begin
          state_next = lct_pkg::S_DECIDE;
        end
      end
      lct_pkg::S_DECIDE: begin
        mreq.key_we  = !found;
        mreq.wr_addr = target;
        state_next   = lct_pkg::S_UPDATE;
      end
      lct_pkg::S_UPDATE: begin
        issue        = (cnt < filled);
        mreq.wr_addr = rd_idx;
        if (rd_pend) begin
          if (rd_idx == upd_slot) begin
            mreq.rank_we    = 1'b1;
            mreq.rank_wdata = '0;
          end else if (age_all || (rank_rdata < limit)) begin
            mreq.rank_we    = 1'b1;
            mreq.rank_wdata = rank_rdata + lct_pkg::RANK_W'(1);
          end
        end
        if (!issue && !rd_pend) begin
          state_next = lct_pkg::S_DONE;
        end
      end
      lct_pkg::S_DONE: begin
        if (res_ready) begin
          state_next = lct_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lct_pkg::S_IDLE;
      end
    endcase
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      filled  <= '0;
      rd_pend <= 1'b0;
      cnt     <= '0;
    end else begin
      rd_pend <= issue;
      if (issue) begin
        cnt <= cnt + lct_pkg::CNT_W'(1);
      end
      if (state == lct_pkg::S_IDLE || state == lct_pkg::S_DECIDE) begin
        cnt <= '0;
      end
      if (state == lct_pkg::S_DECIDE && !found && !full) begin
        filled <= filled + lct_pkg::CNT_W'(1);
      end
    end
  end

  // Scan bookkeeping and result capture
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= cnt[lct_pkg::IDX_W-1:0];
    end
    case (state)
      lct_pkg::S_IDLE: begin
        if (start) begin
          req_key <= start_key;
          found   <= 1'b0;
        end
      end
      lct_pkg::S_SCAN: begin
        if (rd_pend) begin
          // Take the lowest matching slot
          if (!found && key_rdata == req_key) begin
            found      <= 1'b1;
            match_slot <= rd_idx;
            match_rank <= rank_rdata;
          end
          // Track the oldest slot, lowest number on a tie
          if (rd_idx == '0 || rank_rdata > best_rank) begin
            best_slot <= rd_idx;
            best_rank <= rank_rdata;
            best_key  <= key_rdata;
          end
        end
      end
      lct_pkg::S_DECIDE: begin
        upd_slot        <= target;
        limit           <= found ? match_rank : best_rank;
        age_all         <= !found && !full;
        res.hit         <= found;
        res.slot        <= lct_pkg::SLOT_W'(target);
        res.evicted     <= !found && full;
        res.evicted_key <= (!found && full) ? best_key : '0;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: test/lru_cache_tag_lookup_tb.sv
// Testbench: LRU cache tag lookup checked against a built-in LRU tag predictor.
`timescale 1ns / 1ps

module lru_cache_tag_lookup_tb;
  import lct_pkg::*;

  localparam int HOLD_CYCLES  = 700;
  localparam int TAIL_CYCLES  = 2 * ENTRIES + 40;
  localparam int WATCHDOG_MAX = 5000;
  localparam int RANDOM_WORDS = 1450;
  localparam int EVICT_POOL   = 64;

  typedef enum int {
    PICK_RESIDENT,
    PICK_OLDEST,
    PICK_NEWEST,
    PICK_EVICTED,
    PICK_FRESH
  } pick_t;

  logic clk;
  logic rst;

  lct_req_if req_if ();
  lct_rsp_if rsp_if ();

  lru_cache_tag_lookup uut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // Predictor copy of the tag store
  logic [KEY_W-1:0]  cached_keys [ENTRIES];
  logic [RANK_W-1:0] age_rank    [ENTRIES];
  logic [CNT_W-1:0]  resident_count;

  res_t             pending_results [$];
  logic [KEY_W-1:0] evicted_pool [$];

  int  errors = 0;
  int  n_sent;
  int  n_hits;
  int  n_evicts;
  bit  idle_on;
  bit  hold_request = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Make slot s most recent: every valid slot with rank below limit ages by one
  function automatic void promote_slot(int s, int limit);
    for (int i = 0; i < resident_count; i++) begin
      if (i != s && int'(age_rank[i]) < limit) age_rank[i] = age_rank[i] + 1'b1;
    end
    age_rank[s] = '0;
  endfunction

  function automatic int oldest_slot();
    int best;
    best = 0;
    for (int i = 1; i < resident_count; i++) begin
      if (age_rank[i] > age_rank[best]) best = i;
    end
    return best;
  endfunction

  function automatic int newest_slot();
    int found;
    found = 0;
    for (int i = resident_count - 1; i >= 0; i--) begin
      if (age_rank[i] == '0) found = i;
    end
    return found;
  endfunction

  // Work out the result of one lookup and advance the predictor state
  function automatic res_t lookup_predict(logic [KEY_W-1:0] key);
    res_t r;
    int   s;
    bit   found;
    r     = '0;
    s     = 0;
    found = 1'b0;
    for (int i = 0; i < resident_count; i++) begin
      if (!found && cached_keys[i] == key) begin
        s     = i;
        found = 1'b1;
      end
    end
    if (found) begin
      promote_slot(s, int'(age_rank[s]));
    end else if (resident_count < ENTRIES) begin
      s = resident_count;
      resident_count = resident_count + 1'b1;
      cached_keys[s] = key;
      age_rank[s] = '0;
      promote_slot(s, ENTRIES + 1);
    end else begin
      s = oldest_slot();
      r.evicted = 1'b1;
      r.evicted_key = cached_keys[s];
      cached_keys[s] = key;
      promote_slot(s, int'(age_rank[s]));
    end
    r.hit  = found;
    r.slot = s[SLOT_W-1:0];
    return r;
  endfunction

  // Offer one word, after a random gap when idle_on is set; keep valid high for a back-to-back word
  task automatic send_key(input logic [KEY_W-1:0] key);
    int   gap;
    res_t r;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.request_key <= key;
    do @(posedge clk); while (!req_if.ready);
    r = lookup_predict(key);
    pending_results.push_back(r);
    n_sent++;
    if (r.hit) n_hits++;
    if (r.evicted) begin
      n_evicts++;
      evicted_pool.push_back(r.evicted_key);
      if (evicted_pool.size() > EVICT_POOL) void'(evicted_pool.pop_front());
    end
  endtask

  task automatic drop_valid();
    req_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(pick_t kind);
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom());
    if (resident_count == 0) return k;
    case (kind)
      PICK_RESIDENT: k = cached_keys[$urandom_range(0, resident_count - 1)];
      PICK_OLDEST:   k = cached_keys[oldest_slot()];
      PICK_NEWEST:   k = cached_keys[newest_slot()];
      PICK_EVICTED: begin
        if (evicted_pool.size() != 0)
          k = evicted_pool[$urandom_range(0, evicted_pool.size() - 1)];
      end
      default: ;
    endcase
    return k;
  endfunction

  // Key extremes, hit on the newest slot and on an older slot, all while filling
  task automatic test_directed();
    idle_on = 1'b0;
    send_key(31'h0000_0000);
    send_key(31'h0000_0000);
    send_key(31'h7FFF_FFFF);
    send_key(31'h0000_0000);
    send_key(31'h5555_5555);
    send_key(31'h2AAA_AAAA);
    send_key(31'h0000_0001);
    send_key(31'h4000_0000);
    send_key(31'h7FFF_FFFF);
    send_key(31'h2AAA_AAAA);
  endtask

  // Fill every slot, mixing in some hits
  task automatic test_fill();
    idle_on = 1'b1;
    while (resident_count < ENTRIES) begin
      if ($urandom_range(0, 4) == 0) send_key(pick_key(PICK_RESIDENT));
      else send_key(pick_key(PICK_FRESH));
    end
  endtask

  // Full cache: evict, hit the oldest slot, hit the newest, bring an evicted key back
  task automatic test_eviction();
    send_key(pick_key(PICK_FRESH));
    send_key(pick_key(PICK_OLDEST));
    send_key(pick_key(PICK_NEWEST));
    send_key(pick_key(PICK_FRESH));
    send_key(pick_key(PICK_EVICTED));
    send_key(pick_key(PICK_OLDEST));
  endtask

  // Hold the output off for a long stretch while words keep coming
  task automatic test_output_hold();
    idle_on      = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 10; i++) send_key(pick_key(i % 2 ? PICK_RESIDENT : PICK_FRESH));
    idle_on = 1'b1;
  endtask

  // Pause the input until every result has come back, then resume
  task automatic test_drain_pause();
    for (int i = 0; i < 10; i++) send_key(pick_key(PICK_RESIDENT));
    wait_drained();
    for (int i = 0; i < 10; i++) send_key(pick_key(i % 3 ? PICK_OLDEST : PICK_FRESH));
  endtask

  // Mostly hits on resident keys, with evictions, returning keys and fresh keys
  task automatic test_random();
    int    roll;
    pick_t kind;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      idle_on = (i < 400 || i >= 520);
      roll = $urandom_range(0, 99);
      if (roll < 45) kind = PICK_RESIDENT;
      else if (roll < 55) kind = PICK_OLDEST;
      else if (roll < 65) kind = PICK_NEWEST;
      else if (roll < 75) kind = PICK_EVICTED;
      else kind = PICK_FRESH;
      send_key(pick_key(kind));
    end
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic check_result();
    res_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result with none pending: hit=%0b slot=%0d evicted=%0b key=%h",
               $time, rsp_if.hit, rsp_if.slot, rsp_if.evicted, rsp_if.evicted_key);
      errors++;
    end else begin
      want = pending_results.pop_front();
      if (rsp_if.hit !== want.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_if.hit);
        errors++;
      end
      if (rsp_if.slot !== want.slot) begin
        $display("%0t: slot expected %0d actual %0d", $time, want.slot, rsp_if.slot);
        errors++;
      end
      if (rsp_if.evicted !== want.evicted) begin
        $display("%0t: evicted expected %0b actual %0b", $time, want.evicted,
                 rsp_if.evicted);
        errors++;
      end
      if (rsp_if.evicted_key !== want.evicted_key) begin
        $display("%0t: evicted_key expected %h actual %h", $time, want.evicted_key,
                 rsp_if.evicted_key);
        errors++;
      end
    end
  endtask

  // Receive results: check each word, then, when idle_on is set, stall a random number of result cycles
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      // Start the long hold once when the sender asks for it
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        check_result();
        stall_left = idle_on ? $urandom_range(0, 12) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        if (rsp_if.valid) stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no progress for %0d cycles, %0d results pending", $time,
               quiet_cycles, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    n_sent         = 0;
    n_hits         = 0;
    n_evicts       = 0;
    idle_on        = 1'b0;
    resident_count = '0;
    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.request_key <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fill();
    test_eviction();
    test_output_hold();
    test_drain_pause();
    test_random();

    // Let the last results and any trailing activity settle
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d lookups: %0d hits, %0d evictions, fill and full-cache phases",
             n_sent, n_hits, n_evicts);
    $display("with random gaps on both sides, a long output hold and a full drain pause");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches found", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/lct_pkg.sv
rtl/core/lct_if.sv
rtl/core/lct_store.sv
rtl/core/lct_ctrl.sv
rtl/core/lru_cache_tag_lookup.sv
test/lru_cache_tag_lookup_tb.sv
